// ----- design/b32d_pkg.sv -----
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types, constants and the character classifier for the base32
// stream decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

  localparam int unsigned ClsDepthDef = 2;
  localparam int unsigned OutDepthDef = 4;

  localparam int unsigned BufW = 12;
  localparam int unsigned CntW = 4;

  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] CodeA     = 8'h41;
  localparam logic [7:0] CodeZ     = 8'h5A;
  localparam logic [7:0] Code2     = 8'h32;
  localparam logic [7:0] Code7     = 8'h37;
  localparam logic [4:0] DigitBase = 5'd26;

  // Classified character as handed from front to back
  typedef struct packed {
    logic [4:0] sym;
    logic       is_pad;
    logic       is_bad;
    logic       last;
  } cls_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_end;
    logic       bad_input;
  } res_t;

  function automatic cls_t classify(input logic [7:0] ch, input logic last);
    cls_t c;
    c.sym    = 5'd0;
    c.is_pad = (ch == PadChar);
    c.is_bad = 1'b0;
    c.last   = last;
    if (ch >= CodeA && ch <= CodeZ) begin
      c.sym = 5'(ch - CodeA);
    end else if (ch >= Code2 && ch <= Code7) begin
      c.sym = DigitBase + 5'(ch - Code2);
    end else begin
      c.is_bad = !c.is_pad;
    end
    return c;
  endfunction

  function automatic logic [BufW-1:0] low_mask(input logic [CntW-1:0] n);
    return (BufW'(1) << n) - BufW'(1);
  endfunction

endpackage

// ----- design/b32d_front.sv -----
// ----------------------------------------------------------------------------
// b32d_front
// Accepts characters, classifies them and holds them in a short queue
// until the back end takes them.
// ----------------------------------------------------------------------------
module b32d_front import b32d_pkg::*; #(
  parameter int unsigned Depth = ClsDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  logic [7:0] char_code_i,
  input  logic       msg_last_i,
  output logic       full,
  input  logic       take_i,
  output logic       avail_o,
  output cls_t       item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);

  cls_t              mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntQW-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full    = (count_q == CntQW'(Depth));
  assign avail_o = (count_q != '0);
  assign item_o  = mem_q[rptr_q];

  assign do_push = push && !full;
  assign do_pop  = take_i && avail_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= classify(char_code_i, msg_last_i);
    end
  end

endmodule

// ----- design/b32d_back.sv -----
// ----------------------------------------------------------------------------
// b32d_back
// Decoder state: packs 5-bit symbols, emits bytes, runs the padding and
// end-of-message checks and produces up to two results per character.
// ----------------------------------------------------------------------------
module b32d_back import b32d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       avail_i,
  input  cls_t       item_i,
  input  logic       room_i,
  output logic       take_o,
  output logic [1:0] wr_n_o,
  output res_t       res0_o,
  output res_t       res1_o
);

  logic [BufW-1:0] buf_q, buf_d, buf_sum;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_sum, sh;
  logic [2:0]      dc_q, dc_d;
  logic            inpad_q, inpad_d;
  logic [CntW-1:0] padcnt_q, padcnt_d;
  logic            err_q, err_d, err_end;
  logic            emit_byte;
  logic [7:0]      byte_val;
  logic [2:0]      rem;
  res_t            byte_res, end_res;

  assign take_o  = avail_i && room_i;
  assign buf_sum = {buf_q[BufW-6:0], item_i.sym};
  assign cnt_sum = cnt_q + CntW'(5);
  assign sh      = cnt_sum - CntW'(8);

  always_comb begin
    buf_d     = buf_q;
    cnt_d     = cnt_q;
    dc_d      = dc_q;
    inpad_d   = inpad_q;
    padcnt_d  = padcnt_q;
    err_d     = err_q;
    emit_byte = 1'b0;
    byte_val  = 8'(buf_sum >> sh);
    if (inpad_q) begin
      if (!item_i.is_pad) begin
        err_d = 1'b1;
      end else if (padcnt_q < CntW'(8)) begin
        padcnt_d = padcnt_q + 1'b1;
      end
    end else if (item_i.is_pad) begin
      inpad_d  = 1'b1;
      padcnt_d = CntW'(1);
    end else begin
      dc_d = dc_q + 1'b1;
      if (item_i.is_bad) begin
        err_d = 1'b1;
      end else if (cnt_sum >= CntW'(8)) begin
        cnt_d     = sh;
        buf_d     = buf_sum & low_mask(sh);
        emit_byte = !err_q;
      end else begin
        cnt_d = cnt_sum;
        buf_d = buf_sum;
      end
    end

    // end-of-message checks on the updated state
    rem     = dc_d;
    err_end = err_d
            || (rem == 3'd1) || (rem == 3'd3) || (rem == 3'd6)
            || (inpad_d && ((rem == 3'd0) || (padcnt_d != (CntW'(8) - CntW'(rem)))))
            || ((cnt_d != '0) && ((buf_d & low_mask(cnt_d)) != '0));
  end

  always_comb begin
    byte_res.out_byte  = byte_val;
    byte_res.is_end    = 1'b0;
    byte_res.bad_input = 1'b0;
    end_res.out_byte   = 8'd0;
    end_res.is_end     = 1'b1;
    end_res.bad_input  = err_end;
    res0_o = emit_byte ? byte_res : end_res;
    res1_o = end_res;
    wr_n_o = 2'd0;
    if (take_o) begin
      wr_n_o = 2'(emit_byte) + 2'(item_i.last);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q    <= '0;
      cnt_q    <= '0;
      dc_q     <= '0;
      inpad_q  <= 1'b0;
      padcnt_q <= '0;
      err_q    <= 1'b0;
    end else if (take_o) begin
      if (item_i.last) begin
        buf_q    <= '0;
        cnt_q    <= '0;
        dc_q     <= '0;
        inpad_q  <= 1'b0;
        padcnt_q <= '0;
        err_q    <= 1'b0;
      end else begin
        buf_q    <= buf_d;
        cnt_q    <= cnt_d;
        dc_q     <= dc_d;
        inpad_q  <= inpad_d;
        padcnt_q <= padcnt_d;
        err_q    <= err_d;
      end
    end
  end

endmodule

// ----- design/b32d_outq.sv -----
// ----------------------------------------------------------------------------
// b32d_outq
// Result queue: takes up to two results per cycle, hands out the oldest.
// ----------------------------------------------------------------------------
module b32d_outq import b32d_pkg::*; #(
  parameter int unsigned Depth = OutDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] wr_n_i,
  input  res_t       res0_i,
  input  res_t       res1_i,
  output logic       room_o,
  output logic       empty,
  input  logic       pop,
  output res_t       head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);

  res_t             mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, wptr_nx, rptr_q, rptr_d;
  logic [CntQW-1:0] count_q, count_d;
  logic             do_pop;

  assign empty  = (count_q == '0);
  assign room_o = (count_q <= CntQW'(Depth - 2));
  assign head_o = mem_q[rptr_q];
  assign do_pop = pop && !empty;

  assign wptr_nx = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    case (wr_n_i)
      2'd1:    wptr_d = wptr_nx;
      2'd2:    wptr_d = (wptr_nx == PtrW'(Depth - 1)) ? '0 : wptr_nx + 1'b1;
      default: wptr_d = wptr_q;
    endcase
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    count_d = count_q + CntQW'(wr_n_i) - CntQW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_n_i != 2'd0) begin
      mem_q[wptr_q] <= res0_i;
    end
    if (wr_n_i == 2'd2) begin
      mem_q[wptr_nx] <= res1_i;
    end
  end

endmodule

// ----- design/base32_strict_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// base32_strict_stream_decoder
// Strict base32 (A-Z, 2-7, optional '=' padding) decoder, one character per
// request, queue-style handshakes on both sides.
// ----------------------------------------------------------------------------
// One character is accepted per cycle while full is low. The front end
// classifies it into a two-entry queue; the back end takes one character a
// cycle and writes its results (a decoded byte, and on the last character an
// end item carrying the error flag) into a four-entry result queue. The first
// result of a character passes from the front queue into the result queue and
// then shows on the result ports to be popped. The back end takes a character
// only while the result queue has two free slots. With results popped as they
// appear, one character is taken per cycle. Input slows only when results are
// made faster than they are popped; a character that yields both a byte and
// an end item needs two pops. Bytes of a message whose end item has bad_input
// set must be discarded.
module base32_strict_stream_decoder import b32d_pkg::*; #(
  parameter int unsigned ClsDepth = ClsDepthDef,
  parameter int unsigned OutDepth = OutDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code_i,
  input  logic       msg_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       is_end_o,
  output logic       bad_input_o
);

  cls_t       item;
  logic       avail, take, room;
  logic [1:0] wr_n;
  res_t       res0, res1, head;

  b32d_front #(.Depth(ClsDepth)) u_front (
    .clk_i,
    .rst_ni,
    .push,
    .char_code_i,
    .msg_last_i,
    .full,
    .take_i  (take),
    .avail_o (avail),
    .item_o  (item)
  );

  b32d_back u_back (
    .clk_i,
    .rst_ni,
    .avail_i (avail),
    .item_i  (item),
    .room_i  (room),
    .take_o  (take),
    .wr_n_o  (wr_n),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  b32d_outq #(.Depth(OutDepth)) u_outq (
    .clk_i,
    .rst_ni,
    .wr_n_i  (wr_n),
    .res0_i  (res0),
    .res1_i  (res1),
    .room_o  (room),
    .empty,
    .pop,
    .head_o  (head)
  );

  assign out_byte_o  = head.out_byte;
  assign is_end_o    = head.is_end;
  assign bad_input_o = head.bad_input;

endmodule

// ----- tb/base32_strict_stream_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// base32_strict_stream_decoder_tb
// Streams base32 messages into the decoder and checks every result item
// against an in-bench decoder model. Directed messages hit valid padding,
// bad characters, wrong lengths and leftover bits. Random messages are then
// mostly well-formed, some corrupted and some noise. Both sides stall at
// random, and the result side holds off once long enough to back up the input.
// ----------------------------------------------------------------------------
module base32_strict_stream_decoder_tb;
  import b32d_pkg::*;

  localparam int unsigned NumChars  = 1050;
  localparam int unsigned StallLim  = 2000;
  localparam int unsigned HoldAt    = 400;
  localparam int unsigned HoldLen   = 300;
  localparam int unsigned DrainWait = 8;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_req_t;

  typedef logic [7:0] byte_q_t[$];

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  logic [7:0] char_code_i = 8'h00;
  logic       msg_last_i  = 1'b0;
  logic       empty;
  logic       pop         = 1'b0;
  logic [7:0] out_byte_o;
  logic       is_end_o;
  logic       bad_input_o;

  base32_strict_stream_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .char_code_i (char_code_i),
    .msg_last_i  (msg_last_i),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .is_end_o    (is_end_o),
    .bad_input_o (bad_input_o)
  );

  always #4 clk_i = ~clk_i;

  char_req_t   pending_chars[$];
  res_t        expected_res[$];

  // decoder model state
  logic [11:0] acc_bits;
  logic [3:0]  acc_cnt;
  logic [2:0]  data_mod8;
  logic        pad_seen;
  logic [3:0]  pad_total;
  logic        msg_err;

  int unsigned mismatches   = 0;
  int unsigned num_msgs     = 0;
  int unsigned chars_in     = 0;
  int unsigned bytes_out    = 0;
  int unsigned ends_out     = 0;
  int unsigned bad_ends     = 0;
  int unsigned full_stalls  = 0;
  int unsigned idle_cycles  = 0;

  logic        send_took    = 1'b0;
  logic        recv_took    = 1'b0;
  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;
  int unsigned send_calm    = 0;
  int unsigned recv_calm    = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;

  task automatic clear_decoder();
    acc_bits  = '0;
    acc_cnt   = '0;
    data_mod8 = '0;
    pad_seen  = 1'b0;
    pad_total = '0;
    msg_err   = 1'b0;
  endtask

  task automatic decode_char(input logic [7:0] code, input logic last);
    logic [4:0] sym;
    logic       sym_ok;
    logic [3:0] shift;
    res_t       r;
    sym    = '0;
    sym_ok = 1'b1;
    if (code >= CodeA && code <= CodeZ) begin
      sym = 5'(code - CodeA);
    end else if (code >= Code2 && code <= Code7) begin
      sym = 5'(code - Code2) + DigitBase;
    end else begin
      sym_ok = 1'b0;
    end

    if (pad_seen) begin
      if (code != PadChar) msg_err = 1'b1;
      else if (pad_total < 4'd8) pad_total = pad_total + 4'd1;
    end else if (code == PadChar) begin
      pad_seen  = 1'b1;
      pad_total = 4'd1;
    end else begin
      // bad characters still count toward the length
      data_mod8 = data_mod8 + 3'd1;
      if (!sym_ok) begin
        msg_err = 1'b1;
      end else begin
        acc_bits = {acc_bits[6:0], sym};
        acc_cnt  = acc_cnt + 4'd5;
        if (acc_cnt >= 4'd8) begin
          shift      = acc_cnt - 4'd8;
          r.out_byte = 8'(acc_bits >> shift);
          r.is_end   = 1'b0;
          r.bad_input = 1'b0;
          acc_cnt    = shift;
          acc_bits   = acc_bits & ((12'd1 << shift) - 12'd1);
          if (!msg_err) expected_res.push_back(r);
        end
      end
    end

    if (last) begin
      if (data_mod8 inside {3'd1, 3'd3, 3'd6}) msg_err = 1'b1;
      if (pad_seen && (data_mod8 == 3'd0 || pad_total != 4'd8 - data_mod8)) msg_err = 1'b1;
      if (acc_cnt > 0 && acc_cnt < 12 && (acc_bits & ((12'd1 << acc_cnt) - 12'd1)) != 0)
        msg_err = 1'b1;
      r.out_byte  = 8'h00;
      r.is_end    = 1'b1;
      r.bad_input = msg_err;
      expected_res.push_back(r);
      clear_decoder();
    end
  endtask

  function automatic logic [7:0] sym_char(input logic [4:0] v);
    return (v < DigitBase) ? CodeA + 8'(v) : Code2 + 8'(v - DigitBase);
  endfunction

  task automatic add_msg(input byte_q_t m);
    char_req_t c;
    foreach (m[i]) begin
      c.code = m[i];
      c.last = (i == m.size() - 1);
      pending_chars.push_back(c);
    end
    num_msgs++;
  endtask

  task automatic add_str(input string s);
    byte_q_t m;
    for (int i = 0; i < s.len(); i++) m.push_back(s[i]);
    add_msg(m);
  endtask

  task automatic gen_message();
    byte_q_t    m;
    int         kind;
    int         nchr;
    int         lo;
    logic [4:0] v;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // raw noise over the whole byte range
      repeat ($urandom_range(1, 6)) m.push_back(8'($urandom_range(0, 255)));
    end else begin
      do begin
        nchr = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      end while ((nchr % 8) inside {1, 3, 6});
      for (int i = 0; i < nchr; i++) begin
        v = 5'($urandom);
        if (i == nchr - 1) begin
          lo = (5 * nchr) % 8;
          v  = v & ~5'((1 << lo) - 1);
        end
        m.push_back(sym_char(v));
      end
      if ($urandom_range(0, 1) == 1 && (nchr % 8) != 0)
        repeat (8 - nchr % 8) m.push_back(PadChar);
      if (kind >= 75) begin
        case ($urandom_range(0, 4))
          0: m[$urandom_range(0, m.size() - 1)] = 8'($urandom_range(0, 255));
          1: repeat ($urandom_range(1, 10)) m.push_back(PadChar);
          2: if (m.size() > 1) void'(m.pop_back());
          3: m[nchr - 1] = m[nchr - 1] ^ 8'h01;
          default: m.push_back(sym_char(5'($urandom)));
        endcase
      end
    end
    add_msg(m);
  endtask

  // mostly short gaps, a few long, with occasional runs of back-to-back
  function automatic int unsigned draw_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (send_took) send_gap = draw_gap(send_calm);
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        push        <= 1'b1;
        char_code_i <= pending_chars[0].code;
        msg_last_i  <= pending_chars[0].last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off partway through
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (recv_took) recv_gap = draw_gap(recv_calm);
      if (!hold_done && chars_in >= HoldAt) begin
        hold_left = HoldLen;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // accept requests, predict, check results, watchdog
  always @(posedge clk_i) begin
    char_req_t req;
    res_t      want;
    logic      moved;
    send_took <= rst_ni && push && !full;
    recv_took <= rst_ni && pop && !empty;
    if (rst_ni) begin
      moved = 1'b0;
      if (push && full) full_stalls++;
      if (push && !full) begin
        req = pending_chars.pop_front();
        decode_char(req.code, req.last);
        chars_in++;
        moved = 1'b1;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result: out_byte %02h is_end %0b bad_input %0b",
                   $time, out_byte_o, is_end_o, bad_input_o);
          mismatches++;
        end else begin
          want = expected_res.pop_front();
          if (out_byte_o !== want.out_byte) begin
            $display("%0t: out_byte expected %02h, got %02h", $time, want.out_byte, out_byte_o);
            mismatches++;
          end
          if (is_end_o !== want.is_end) begin
            $display("%0t: is_end expected %0b, got %0b", $time, want.is_end, is_end_o);
            mismatches++;
          end
          if (bad_input_o !== want.bad_input) begin
            $display("%0t: bad_input expected %0b, got %0b", $time, want.bad_input,
                     bad_input_o);
            mismatches++;
          end
          if (want.is_end) begin
            ends_out++;
            if (want.bad_input) bad_ends++;
          end else begin
            bytes_out++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLim) begin
        $display("%0t: watchdog: no request moved for %0d cycles, %0d chars and %0d results pending",
                 $time, idle_cycles, pending_chars.size(), expected_res.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    byte_q_t m;
    clear_decoder();

    // directed messages
    add_str("MY======");   // one byte, full padding
    add_str("MZXW6YTB");   // five bytes, no padding needed
    add_str("MZ");         // nonzero leftover bits
    add_str("M");          // length remainder 1
    add_str("MY=A");       // data after padding
    add_str("=");          // padding with no data
    m = '{8'h00, 8'hFF};   // characters outside the alphabet at both code extremes
    add_msg(m);

    while (pending_chars.size() < NumChars + 26) gen_message();

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i); while (pending_chars.size() != 0 || expected_res.size() != 0);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d chars in %0d messages; checked %0d bytes and %0d end items (%0d invalid)",
             chars_in, num_msgs, bytes_out, ends_out, bad_ends);
    $display("Input held off by full for %0d cycles, %0d mismatches", full_stalls, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/b32d_pkg.sv
design/b32d_front.sv
design/b32d_back.sv
design/b32d_outq.sv
design/base32_strict_stream_decoder.sv
tb/base32_strict_stream_decoder_tb.sv
